FILE: src/iirdf1_pkg.sv
`default_nettype none

package iirdf1_pkg;

  // coefficient format: signed Q4.27 in a 32-bit word
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned HIST_MAX   = 4;

  // reset value of b0 (1.0 in Q4.27)
  localparam logic [COEF_W-1:0] B0_RESET = 32'd134217728;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF_COEF_0_1 = 8'd0,
    REG_FF_COEF_2_3 = 8'd1,
    REG_FF_COEF_4   = 8'd2,
    REG_FB_COEF_1_2 = 8'd3,
    REG_FB_COEF_3_4 = 8'd4
  } cfg_reg_e;

  typedef logic [COEF_W-1:0] coef_t;

  // feedforward b0..b4, feedback a1..a4
  typedef struct packed {
    coef_t [HIST_MAX:0] b;
    coef_t [HIST_MAX:1] a;
  } coef_set_t;

endpackage

`default_nettype wire

FILE: src/iirdf1_coef_regs.sv
`default_nettype none

module iirdf1_coef_regs (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [iirdf1_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [iirdf1_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output iirdf1_pkg::coef_set_t                     coef_o
);

  localparam int unsigned CW = iirdf1_pkg::COEF_W;

  iirdf1_pkg::coef_set_t coef_q;

  // writes are always accepted; cfg_ready_o is tied high
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // b0 = 1.0, every other tap zero
      coef_q.b <= {{(iirdf1_pkg::HIST_MAX*CW){1'b0}}, iirdf1_pkg::B0_RESET};
      coef_q.a <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        iirdf1_pkg::REG_FF_COEF_0_1: begin
          coef_q.b[0] <= cfg_data_i[CW-1:0];
          coef_q.b[1] <= cfg_data_i[2*CW-1:CW];
        end
        iirdf1_pkg::REG_FF_COEF_2_3: begin
          coef_q.b[2] <= cfg_data_i[CW-1:0];
          coef_q.b[3] <= cfg_data_i[2*CW-1:CW];
        end
        iirdf1_pkg::REG_FF_COEF_4: begin
          coef_q.b[4] <= cfg_data_i[CW-1:0];
        end
        iirdf1_pkg::REG_FB_COEF_1_2: begin
          coef_q.a[1] <= cfg_data_i[CW-1:0];
          coef_q.a[2] <= cfg_data_i[2*CW-1:CW];
        end
        iirdf1_pkg::REG_FB_COEF_3_4: begin
          coef_q.a[3] <= cfg_data_i[CW-1:0];
          coef_q.a[4] <= cfg_data_i[2*CW-1:CW];
        end
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

FILE: src/iirdf1_datapath.sv
`default_nettype none

module iirdf1_datapath #(
  parameter int unsigned TAPS           = 5,
  parameter int unsigned SAMPLE_BITS    = 16,
  parameter int unsigned COEF_FRAC_BITS = 27
) (
  input  wire logic [SAMPLE_BITS-1:0]             x_i,
  input  wire logic [TAPS-2:0][SAMPLE_BITS-1:0]   x_hist_i,
  input  wire logic [TAPS-2:0][SAMPLE_BITS-1:0]   y_hist_i,
  input  iirdf1_pkg::coef_set_t                   coef_i,
  output logic [SAMPLE_BITS-1:0]                  y_o,
  output logic                                    sat_o
);

  localparam int unsigned PROD_W = SAMPLE_BITS + iirdf1_pkg::COEF_W;
  // nine products plus rounding constant fit in four guard bits
  localparam int unsigned ACC_W  = PROD_W + 4;
  localparam int unsigned Q_W    = ACC_W - COEF_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] RND =
    {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

  logic signed [ACC_W-1:0]        acc;
  logic signed [Q_W-1:0]          q;
  logic [Q_W-SAMPLE_BITS:0]       q_top;
  logic signed [PROD_W-1:0]       p_ff0;
  logic signed [PROD_W-1:0]       p_ff [TAPS-1];
  logic signed [PROD_W-1:0]       p_fb [TAPS-1];

  // parallel products
  always_comb begin
    p_ff0 = $signed(x_i) * $signed(coef_i.b[0]);
    for (int k = 0; k < int'(TAPS) - 1; k++) begin
      p_ff[k] = $signed(x_hist_i[k]) * $signed(coef_i.b[k+1]);
      p_fb[k] = $signed(y_hist_i[k]) * $signed(coef_i.a[k+1]);
    end
  end

  // exact sum with half-up rounding constant
  always_comb begin
    acc = ACC_W'(p_ff0) + RND;
    for (int k = 0; k < int'(TAPS) - 1; k++) begin
      acc = acc + ACC_W'(p_ff[k]) - ACC_W'(p_fb[k]);
    end
  end

  assign q     = acc[ACC_W-1:COEF_FRAC_BITS];
  assign q_top = q[Q_W-1:SAMPLE_BITS-1];

  // clip to signed sample range
  always_comb begin
    if ((&q_top) || !(|q_top)) begin
      y_o   = q[SAMPLE_BITS-1:0];
      sat_o = 1'b0;
    end else if (q[Q_W-1]) begin
      y_o   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      sat_o = 1'b1;
    end else begin
      y_o   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      sat_o = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: src/iir_filter_direct_form_one.sv
`default_nettype none

// channel   direction  handshake                   payload
// cfg       in         cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_ready_o     in_sample_i, in_last_i
// out       out        out_valid_o / out_ready_i   out_sample_o, out_saturated_o, out_last_o
//
// one sample per cycle while out_ready_i is high; samples pass input then result register
// the feedback loop (multiply-accumulate of the histories into y) closes via y_hist_q
// reset clears both histories, coefficients return to b0 = 1.0, all others zero
// a stalled output holds the result register; the input register still fills behind it
// coefficient writes complete at once and are expected only while the filter is idle

module iir_filter_direct_form_one #(
  parameter int unsigned TAPS           = 5,
  parameter int unsigned SAMPLE_BITS    = 16,
  parameter int unsigned COEF_FRAC_BITS = 27
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration write channel
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [iirdf1_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [iirdf1_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // sample input
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]              in_sample_i,
  input  wire logic                                in_last_i,
  // filtered output
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [SAMPLE_BITS-1:0]                   out_sample_o,
  output logic                                     out_saturated_o,
  output logic                                     out_last_o
);

  iirdf1_pkg::coef_set_t coef;

  // input register
  logic                                s1_valid_q;
  logic [SAMPLE_BITS-1:0]              x_q;
  logic                                last_q;

  // result register
  logic                                out_valid_q;
  logic [SAMPLE_BITS-1:0]              out_sample_q;
  logic                                out_sat_q;
  logic                                out_last_q;

  // histories, newest at index 0
  logic [TAPS-2:0][SAMPLE_BITS-1:0]    x_hist_q, x_hist_d;
  logic [TAPS-2:0][SAMPLE_BITS-1:0]    y_hist_q, y_hist_d;

  logic [SAMPLE_BITS-1:0]              y;
  logic                                y_sat;
  logic                                advance;

  iirdf1_coef_regs u_coef_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  iirdf1_datapath #(
    .TAPS           (TAPS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .x_i      (x_q),
    .x_hist_i (x_hist_q),
    .y_hist_i (y_hist_q),
    .coef_i   (coef),
    .y_o      (y),
    .sat_o    (y_sat)
  );

  // the held sample moves into the result register when that slot is free or draining
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      x_q    <= in_sample_i;
      last_q <= in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_sample_q <= y;
      out_sat_q    <= y_sat;
      out_last_q   <= last_q;
    end
  end

  // shift both histories by one sample
  always_comb begin
    for (int k = int'(TAPS) - 2; k > 0; k--) begin
      x_hist_d[k] = x_hist_q[k-1];
      y_hist_d[k] = y_hist_q[k-1];
    end
    x_hist_d[0] = x_q;
    y_hist_d[0] = y;
  end

  // histories carry on across blocks, cleared only by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_hist_q <= '0;
      y_hist_q <= '0;
    end else if (advance) begin
      x_hist_q <= x_hist_d;
      y_hist_q <= y_hist_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_sample_o    = out_sample_q;
  assign out_saturated_o = out_sat_q;
  assign out_last_o      = out_last_q;

  // a computed sample always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("result register not loaded after advance");

  // fed-back value equals the delivered sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (y_hist_q[0] == out_sample_q) && (x_hist_q[0] == $past(x_q)))
    else $error("history head does not match last result");

  // histories move only with a sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(y_hist_q) && $stable(x_hist_q))
    else $error("history changed without a sample");

  // no room anywhere means no new input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while pipeline full");

endmodule

`default_nettype wire

FILE: tb/iir_filter_direct_form_one_tb.sv
module iir_filter_direct_form_one_tb;
  import iirdf1_pkg::*;

  // filter configuration under test
  localparam int unsigned TAPS           = 5;
  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned COEF_FRAC_BITS = 27;

  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  // random part length and run guards
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned DRAIN_CYCLES = 4;      // pipeline is two deep, plus margin
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned MAX_REPORTS  = 10;

  // coefficient mixes for the random phases
  typedef enum int unsigned {
    MIX_FULL,   // any 32-bit word, saturates a lot
    MIX_HALF,   // within +-0.5
    MIX_EDGE,   // extreme words, zero and unity
    MIX_UNIT    // within +-1.0
  } coef_mix_e;

  // receiver stall patterns
  typedef enum int unsigned {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC,
    RX_LONG
  } rx_mode_e;

  typedef struct {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   sat;
    logic                   last;
  } filt_out_t;

  // scoreboard: own copy of coefficients and histories, predicts each output
  class df1_scoreboard;
    coef_t                         ff_taps[TAPS];
    coef_t                         fb_taps[TAPS];
    logic signed [SAMPLE_BITS-1:0] x_hist[TAPS-1];
    logic signed [SAMPLE_BITS-1:0] y_hist[TAPS-1];
    filt_out_t                     expected_q[$];
    int unsigned                   mismatches;

    function new();
      foreach (ff_taps[k]) begin
        ff_taps[k] = '0;
        fb_taps[k] = '0;
      end
      ff_taps[0] = B0_RESET;
      foreach (x_hist[k]) begin
        x_hist[k] = '0;
        y_hist[k] = '0;
      end
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FF_COEF_0_1: begin
          ff_taps[0] = data[31:0];
          ff_taps[1] = data[63:32];
        end
        REG_FF_COEF_2_3: begin
          ff_taps[2] = data[31:0];
          ff_taps[3] = data[63:32];
        end
        REG_FF_COEF_4: ff_taps[4] = data[31:0];
        REG_FB_COEF_1_2: begin
          fb_taps[1] = data[31:0];
          fb_taps[2] = data[63:32];
        end
        REG_FB_COEF_3_4: begin
          fb_taps[3] = data[31:0];
          fb_taps[4] = data[63:32];
        end
        default: ;
      endcase
    endfunction

    function void predict_sample(logic [SAMPLE_BITS-1:0] x, logic last);
      longint    acc;
      longint    q;
      filt_out_t r;
      acc = longint'($signed(ff_taps[0])) * longint'($signed(x));
      for (int k = 0; k < TAPS - 1; k++) begin
        acc += longint'($signed(ff_taps[k+1])) * longint'(x_hist[k]);
        acc -= longint'($signed(fb_taps[k+1])) * longint'(y_hist[k]);
      end
      // round half up, then floor shift
      acc += longint'(1) << (COEF_FRAC_BITS - 1);
      q = acc >>> COEF_FRAC_BITS;
      r.last = last;
      if (q > SAMPLE_MAX) begin
        r.sample = SAMPLE_BITS'(SAMPLE_MAX);
        r.sat    = 1'b1;
      end else if (q < SAMPLE_MIN) begin
        r.sample = SAMPLE_BITS'(SAMPLE_MIN);
        r.sat    = 1'b1;
      end else begin
        r.sample = SAMPLE_BITS'(q);
        r.sat    = 1'b0;
      end
      for (int k = TAPS - 2; k > 0; k--) begin
        x_hist[k] = x_hist[k-1];
        y_hist[k] = y_hist[k-1];
      end
      x_hist[0] = x;
      y_hist[0] = r.sample;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [SAMPLE_BITS-1:0] s, logic sat, logic last);
      filt_out_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected output: sample %0d sat %b last %b", $signed(s), sat, last);
        return;
      end
      e = expected_q.pop_front();
      if (s !== e.sample || sat !== e.sat || last !== e.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("output mismatch: expected sample %0d sat %b last %b, got %0d %b %b",
                   $signed(e.sample), e.sat, e.last, $signed(s), sat, last);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // clock, reset and every block input start at known values
  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i      = '0;
  logic                   in_valid_i      = 1'b0;
  logic                   in_ready_o;
  logic [SAMPLE_BITS-1:0] in_sample_i     = '0;
  logic                   in_last_i       = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i     = 1'b0;
  logic [SAMPLE_BITS-1:0] out_sample_o;
  logic                   out_saturated_o;
  logic                   out_last_o;

  df1_scoreboard sb = new();

  // receiver pattern state
  rx_mode_e    rx_mode  = RX_ALWAYS;
  int unsigned rx_left  = 0;
  int unsigned rx_phase = 0;

  int unsigned cycle_cnt = 0;

  iir_filter_direct_form_one #(
    .TAPS          (TAPS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_sample_i    (in_sample_i),
    .in_last_i      (in_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_sample_o   (out_sample_o),
    .out_saturated_o(out_saturated_o),
    .out_last_o     (out_last_o)
  );

  // 12 unit period
  initial begin
    forever begin
      #6 clk_i = ~clk_i;
    end
  end

  // monitor: every transaction is seen at the rising edge, inputs were set at the falling one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        sb.write_reg(cfg_index_i, cfg_data_i);
      // note the input before checking, so a result that appears with its input would still line up
      if (in_valid_i && in_ready_o)
        sb.predict_sample(in_sample_i, in_last_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(out_sample_o, out_saturated_o, out_last_o);
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: picks a new stall pattern whenever its run counter rx_left reaches zero
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(RX_ALWAYS, RX_LONG));
      rx_left <= $urandom_range(40, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= (rx_phase == 7) ? 0 : rx_phase + 1;
    case (rx_mode)
      RX_ALWAYS:   out_ready_i <= 1'b1;
      RX_RANDOM:   out_ready_i <= ($urandom_range(0, 9) < 7);
      RX_PERIODIC: out_ready_i <= (rx_phase < 5);
      default:     out_ready_i <= (rx_phase >= 6);   // long stalls
    endcase
  end

  // full-scale, small and random samples
  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_BITS'(SAMPLE_MAX);
      1:       return SAMPLE_BITS'(SAMPLE_MIN);
      2, 3:    return SAMPLE_BITS'($urandom_range(0, 255) - 128);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic coef_t rand_coef(coef_mix_e mix);
    case (mix)
      MIX_FULL: return coef_t'($urandom());
      MIX_HALF: return coef_t'($urandom_range(0, 1 << 27) - (1 << 26));
      MIX_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return '0;
          default: return B0_RESET;
        endcase
      end
      default:  return coef_t'($urandom_range(0, 1 << 28) - (1 << 27));
    endcase
  endfunction

  // leaves cfg_valid_i high so writes can run back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // every output has arrived and the pipeline has settled
  task automatic wait_idle();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // writes all five registers, optionally one stray index past the end
  task automatic apply_coefs(input coef_set_t cs, input bit stray);
    logic [CFG_IDX_W-1:0] bad_idx;
    bad_idx = CFG_IDX_W'($urandom_range(int'(REG_FB_COEF_3_4) + 1, (1 << CFG_IDX_W) - 1));
    wait_idle();
    write_reg(REG_FF_COEF_0_1, {cs.b[1], cs.b[0]});
    write_reg(REG_FF_COEF_2_3, {cs.b[3], cs.b[2]});
    // upper half of the single-coefficient register must be ignored
    write_reg(REG_FF_COEF_4,   {coef_t'($urandom()), cs.b[4]});
    write_reg(REG_FB_COEF_1_2, {cs.a[2], cs.a[1]});
    write_reg(REG_FB_COEF_3_4, {cs.a[4], cs.a[3]});
    if (stray)
      write_reg(bad_idx, {$urandom(), $urandom()});
    cfg_valid_i <= 1'b0;
  endtask

  // holds in_valid_i high; the caller lowers it when a burst ends
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic last);
    in_valid_i  <= 1'b1;
    in_sample_i <= s;
    in_last_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // bursts of random length with random gaps, a zero gap keeps the stream going
  task automatic send_random(input int unsigned count);
    int unsigned left;
    int unsigned burst;
    int unsigned gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 48);
      if (burst > left)
        burst = left;
      repeat (burst) send_sample(random_sample(), ($urandom_range(0, 15) == 0));
      left -= burst;
      gap = $urandom_range(0, 7);
      if (gap != 0 && left > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    coef_set_t   cs;
    coef_mix_e   ff_mix;
    coef_mix_e   fb_mix;
    int unsigned sent;
    int unsigned len;

    // reset once, released at a falling edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset coefficients give a unity pass-through, end-of-block mark on some samples
    send_sample(16'h0000, 1'b0);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b1);
    send_sample(SAMPLE_BITS'(SAMPLE_MIN), 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);
    in_valid_i <= 1'b0;

    // largest positive gain, clips both ways; stray write must change nothing
    cs      = '0;
    cs.b[0] = 32'h7FFF_FFFF;
    apply_coefs(cs, 1'b1);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
    send_sample(SAMPLE_BITS'(SAMPLE_MIN), 1'b0);
    send_sample(16'h0001, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    in_valid_i <= 1'b0;

    // most negative gain and extreme feedback, saturated value goes back into the loop
    cs      = '0;
    cs.b[0] = 32'h8000_0000;
    cs.b[1] = rand_coef(MIX_FULL);
    cs.b[2] = rand_coef(MIX_FULL);
    cs.b[3] = rand_coef(MIX_FULL);
    cs.b[4] = 32'h7FFF_FFFF;
    cs.a[1] = 32'h7FFF_FFFF;
    cs.a[4] = 32'h8000_0000;
    apply_coefs(cs, 1'b0);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
    send_sample(SAMPLE_BITS'(SAMPLE_MIN), 1'b0);
    send_sample(16'd100, 1'b0);
    send_sample(-16'sd100, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b0);
    in_valid_i <= 1'b0;

    // a1 = -1.0 makes an integrator that runs into the rail, history spans a block end
    cs      = '0;
    cs.b[0] = B0_RESET;
    cs.a[1] = 32'hF800_0000;
    apply_coefs(cs, 1'b0);
    send_sample(16'd30000, 1'b1);
    send_sample(16'd30000, 1'b0);
    send_sample(SAMPLE_BITS'(SAMPLE_MIN), 1'b0);
    send_sample(SAMPLE_BITS'(SAMPLE_MIN), 1'b0);
    send_sample(16'd5, 1'b1);
    in_valid_i <= 1'b0;

    // random phases, each with a fresh coefficient set written while idle
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = $urandom_range(60, 240);
      if (len > RANDOM_ITEMS - sent)
        len = RANDOM_ITEMS - sent;
      ff_mix = coef_mix_e'($urandom_range(MIX_FULL, MIX_UNIT));
      fb_mix = coef_mix_e'($urandom_range(MIX_FULL, MIX_UNIT));
      for (int k = 0; k <= HIST_MAX; k++)
        cs.b[k] = rand_coef(ff_mix);
      for (int k = 1; k <= HIST_MAX; k++)
        cs.a[k] = rand_coef(fb_mix);
      // now and then a plain feedforward filter
      if ($urandom_range(0, 5) == 0)
        cs.a = '0;
      apply_coefs(cs, ($urandom_range(0, 2) == 0));
      send_random(len);
      sent += len;
    end

    // drain, then give any stray output a chance to show up
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
